>>> rtl/tpfl_pkg.sv
// Shared constants, codes and types of the two-pool free-list allocator.
`default_nettype none
package tpfl_pkg;

    localparam int POOL_SLOTS = 128;
    localparam int NUM_POOLS  = 2;
    localparam int IDX_W      = 7;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int ADDR_W     = SLOT_W + $clog2(NUM_POOLS);
    localparam int MEM_DEPTH  = NUM_POOLS * POOL_SLOTS;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_NULL_FREE  = 2'd2,
        STAT_NOT_IN_USE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] low_mark;
    } t_pool_meta;

    typedef struct packed {
        logic              cnt_we;
        logic              pool;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  low_mark;
        logic              iu_set;
        logic [ADDR_W-1:0] iu_addr;
    } t_meta_upd;

endpackage
`default_nettype wire

>>> rtl/tpfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/tpfl_meta.sv
// Per-pool free counts, low-water marks and in-use written flags.
`default_nettype none
module tpfl_meta (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire tpfl_pkg::t_meta_upd                        i_upd,
    input  wire logic [tpfl_pkg::ADDR_W-1:0]                i_vld_addr,
    output logic                                            o_vld,
    output tpfl_pkg::t_pool_meta [tpfl_pkg::NUM_POOLS-1:0]  o_meta
);
    import tpfl_pkg::*;

    t_pool_meta [NUM_POOLS-1:0] r_meta;
    logic       [MEM_DEPTH-1:0] r_iu_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_meta[p].count    <= CNT_W'(POOL_SLOTS);
                r_meta[p].low_mark <= CNT_W'(POOL_SLOTS);
            end
            r_iu_vld <= '0;
        end else begin
            if (i_upd.cnt_we) begin
                r_meta[i_upd.pool].count    <= i_upd.count;
                r_meta[i_upd.pool].low_mark <= i_upd.low_mark;
            end
            if (i_upd.iu_set) begin
                r_iu_vld[i_upd.iu_addr] <= 1'b1;
            end
        end
    end

    assign o_meta = r_meta;
    assign o_vld  = r_iu_vld[i_vld_addr];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta[0].count <= CNT_W'(POOL_SLOTS) && r_meta[1].count <= CNT_W'(POOL_SLOTS))
        else $error("free count above pool size");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta[0].low_mark <= r_meta[0].count && r_meta[1].low_mark <= r_meta[1].count)
        else $error("low-water mark above free count");

endmodule
`default_nettype wire

>>> rtl/two_pool_free_list_allocator.sv
// Top level: request sequencer, stack and in-use memories, result register.
//
// channel  | direction | handshake                  | word
// ---------+-----------+----------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_ready    | command, pool, slot_index, null_handle
// out      | output    | o_out_valid / i_out_ready  | granted_slot, result_status
//
// Per word: the accept cycle reads the stack top and the in-use bit; in the execute state,
// once the result register is free, it writes the needed memories and the result register.
// Reset: counts and low-water marks to POOL_SLOTS, written flags cleared; no clearing pass.
// Stack entries below the low-water mark read as their own index.
// A full result register holds the sequencer until the result is taken.
`default_nettype none
module two_pool_free_list_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_command,
    input  wire logic                        i_pool,
    input  wire logic [tpfl_pkg::IDX_W-1:0]  i_slot_index,
    input  wire logic                        i_null_handle,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [tpfl_pkg::IDX_W-1:0]  o_granted_slot,
    output logic      [1:0]                  o_result_status
);
    import tpfl_pkg::*;

    t_state r_state, n_state;

    t_cmd             r_cmd;
    logic             r_pool;
    logic [IDX_W-1:0] r_slot;
    logic             r_null;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_granted;
    t_status          r_status;

    logic in_acc, commit;

    t_pool_meta [NUM_POOLS-1:0] meta;
    t_pool_meta  cur;
    t_meta_upd   upd;
    logic        iu_vld;

    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    logic [SLOT_W-1:0] stk_wdata;
    logic [ADDR_W-1:0] stk_raddr;
    logic [SLOT_W-1:0] stk_rdata;
    logic [CNT_W-1:0]  acc_top;

    logic              iu_we;
    logic [ADDR_W-1:0] iu_waddr;
    logic              iu_wdata;
    logic [ADDR_W-1:0] iu_raddr;
    logic              iu_rdata;

    logic [CNT_W-1:0]  top_idx;
    logic [SLOT_W-1:0] pop_slot;
    logic              used;
    t_status           n_status;
    logic [IDX_W-1:0]  n_granted;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_EXEC: commit     = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                commit     = 1'b0;
            end
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= t_cmd'(i_command);
            r_pool <= i_pool;
            r_slot <= i_slot_index;
            r_null <= i_null_handle;
        end
        if (commit) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    // read addresses on accept
    assign acc_top   = meta[i_pool].count - CNT_W'(1);
    assign stk_raddr = {i_pool, acc_top[SLOT_W-1:0]};
    assign iu_raddr  = {i_pool, SLOT_W'(i_slot_index)};

    // execute
    assign cur      = meta[r_pool];
    assign top_idx  = cur.count - CNT_W'(1);
    assign pop_slot = (top_idx < cur.low_mark) ? top_idx[SLOT_W-1:0] : stk_rdata;
    assign used     = iu_vld && iu_rdata;

    always_comb begin
        n_status     = STAT_OK;
        n_granted    = '0;
        upd          = '0;
        upd.pool     = r_pool;
        upd.count    = cur.count;
        upd.low_mark = cur.low_mark;
        stk_we       = 1'b0;
        stk_waddr    = {r_pool, cur.count[SLOT_W-1:0]};
        stk_wdata    = SLOT_W'(r_slot);
        iu_we        = 1'b0;
        iu_waddr     = {r_pool, SLOT_W'(r_slot)};
        iu_wdata     = 1'b0;
        if (r_cmd == CMD_ALLOC) begin
            if (cur.count == '0 || cur.count > CNT_W'(POOL_SLOTS)) begin
                n_status = STAT_EXHAUSTED;
            end else begin
                n_granted  = IDX_W'(pop_slot);
                upd.cnt_we = commit;
                upd.count  = top_idx;
                if (top_idx < cur.low_mark) begin
                    upd.low_mark = top_idx;
                end
                iu_we       = commit;
                iu_waddr    = {r_pool, pop_slot};
                iu_wdata    = 1'b1;
                upd.iu_set  = commit;
                upd.iu_addr = {r_pool, pop_slot};
            end
        end else if (r_null) begin
            n_status = STAT_NULL_FREE;
        end else if (int'(r_slot) >= POOL_SLOTS || !used
                     || cur.count >= CNT_W'(POOL_SLOTS)) begin
            n_status = STAT_NOT_IN_USE;
        end else begin
            stk_we     = commit;
            iu_we      = commit;
            upd.cnt_we = commit;
            upd.count  = cur.count + CNT_W'(1);
        end
    end

    tpfl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MEM_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (in_acc),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    tpfl_ram #(
        .WIDTH (1),
        .DEPTH (MEM_DEPTH)
    ) u_in_use_ram (
        .i_clk   (i_clk),
        .i_we    (iu_we),
        .i_waddr (iu_waddr),
        .i_wdata (iu_wdata),
        .i_re    (in_acc),
        .i_raddr (iu_raddr),
        .o_rdata (iu_rdata)
    );

    tpfl_meta u_meta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (upd),
        .i_vld_addr ({r_pool, SLOT_W'(r_slot)}),
        .o_vld      (iu_vld),
        .o_meta     (meta)
    );

    assign o_out_valid     = r_out_valid;
    assign o_granted_slot  = r_granted;
    assign o_result_status = r_status;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_EXEC)
        else $error("accepted word did not enter execute");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("completed word produced no result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_status != STAT_OK |-> o_granted_slot == '0)
        else $error("nonzero slot on a failed result");

endmodule
`default_nettype wire
